@@ sv/cpr_pkg.sv @@
// Shared types, widths and constants for the Cartesian-to-polar pixel remap.
package cpr_pkg;

    localparam int COORD_W      = 12;
    localparam int DIM_W        = 13;
    localparam int COLOR_W      = 24;
    localparam int ROW_W        = 14;
    localparam int OFS_W        = 13;
    localparam int GUARD_BITS   = 8;
    localparam int CORDIC_W     = 24;
    localparam int MAG_W        = CORDIC_W - 1;
    localparam int TURN_W       = 20;
    localparam int ANGLE_W      = 22;
    localparam int ATAN_W       = 18;
    localparam int GAIN_W       = 20;
    localparam int MAG_PROD_W   = MAG_W + GAIN_W;
    localparam int MAG_SHIFT    = 20 + GUARD_BITS;
    localparam int RADIUS_W     = 14;
    localparam int TURN_PROD_W  = TURN_W + DIM_W;
    localparam int MAX_DIM      = 4096;
    localparam int CFG_IDX_W    = 1;

    localparam logic [DIM_W-1:0]  DIM_RESET     = 13'd1024;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q20  = 20'd636751;
    localparam logic [TURN_W-1:0] TURN_QUARTER  = 20'h40000;
    localparam logic [TURN_W-1:0] TURN_HALF     = 20'h80000;
    localparam logic [TURN_W-1:0] TURN_3QUARTER = 20'hC0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                       axis;
        logic [COORD_W-1:0]         axis_radius;
        logic [TURN_W-1:0]          axis_turn;
        logic signed [CORDIC_W-1:0] u;
        logic signed [CORDIC_W-1:0] v;
        logic signed [ANGLE_W-1:0]  z;
        logic [COLOR_W-1:0]         color;
    } cordic_data_t;

    typedef struct packed {
        logic [COORD_W-1:0] dest_col;
        logic [ROW_W-1:0]   dest_row;
        logic [COLOR_W-1:0] dest_color;
        logic               in_range;
    } result_t;

    // Angle of each micro-rotation, atan(2^-i) as a Q20 fraction of a turn.
    function automatic logic [ATAN_W-1:0] atan_turn(input int idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            0:       val = 18'd131072;
            1:       val = 18'd77376;
            2:       val = 18'd40884;
            3:       val = 18'd20753;
            4:       val = 18'd10417;
            5:       val = 18'd5213;
            6:       val = 18'd2607;
            7:       val = 18'd1304;
            8:       val = 18'd652;
            9:       val = 18'd326;
            10:      val = 18'd163;
            11:      val = 18'd81;
            12:      val = 18'd41;
            13:      val = 18'd20;
            14:      val = 18'd10;
            15:      val = 18'd5;
            16:      val = 18'd3;
            17:      val = 18'd1;
            18:      val = 18'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ sv/cpr_ifs.sv @@
// Valid/ready channel interfaces for source pixels and remapped results.
interface cpr_src_if import cpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [COLOR_W-1:0] src_color;

    modport source (output valid, output src_col, output src_row, output src_color,
                    input ready);
    modport sink (input valid, input src_col, input src_row, input src_color,
                  output ready);
endinterface

interface cpr_dst_if import cpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] dest_col;
    logic [ROW_W-1:0]   dest_row;
    logic [COLOR_W-1:0] dest_color;
    logic               in_range;

    modport source (output valid, output dest_col, output dest_row, output dest_color,
                    output in_range, input ready);
    modport sink (input valid, input dest_col, input dest_row, input dest_color,
                  input in_range, output ready);
endinterface

@@ sv/cartesian_to_polar_pixel_remap.sv @@
// Top level of the Cartesian-to-polar pixel remap pipeline.
//
//   Channel  Direction  Carries
//   src      sink       src_col, src_row, src_color
//   dst      source     dest_col, dest_row, dest_color, in_range
//   cfg      write      cfg_index selects image_width or image_height
//
// One item is accepted per cycle while the pipeline is not stalled; each passes the prep
// register, one CORDIC stage per iteration and the scale register to the output register.
// Reset clears all valid bits and loads 1024 into both image dimensions.
// A stall on dst lets the next item fill the skid entry, whose registered flag freezes every stage.
module cartesian_to_polar_pixel_remap import cpr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    cpr_src_if.sink              src,
    cpr_dst_if.source            dst
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             en;
    logic             stage_valid [CORDIC_STEPS+1];
    cordic_data_t     stage_data  [CORDIC_STEPS+1];
    logic             scale_valid;
    result_t          scale_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    assign src.ready = en;

    cpr_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (src.valid),
        .src_col   (src.src_col),
        .src_row   (src.src_row),
        .src_color (src.src_color),
        .width     (width_reg),
        .height    (height_reg),
        .valid_reg (stage_valid[0]),
        .data_reg  (stage_data[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        cpr_cordic_stage #(.STEP(g)) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .valid_reg (stage_valid[g+1]),
            .data_reg  (stage_data[g+1])
        );
    end

    cpr_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stage_valid[CORDIC_STEPS]),
        .in_data   (stage_data[CORDIC_STEPS]),
        .width     (width_reg),
        .height    (height_reg),
        .valid_reg (scale_valid),
        .result    (scale_result)
    );

    cpr_skid u_skid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (scale_valid),
        .in_data  (scale_result),
        .in_ready (en),
        .dst      (dst)
    );

    // The skid entry only fills behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n) !en |-> dst.valid)
        else $error("skid entry holds an item while the output register is empty");

    // The pipeline freezes only after a result was refused.
    assert property (@(posedge clk) disable iff (!rst_n)
                     $fell(en) |-> $past(dst.valid && !dst.ready))
        else $error("pipeline stalled without a refused result");

    // A frozen pipeline keeps its last stage in place.
    assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(scale_valid))
        else $error("last stage changed during a stall");

endmodule

@@ sv/cpr_prep.sv @@
// Front stage: center offsets, on-axis results and CORDIC pre-rotation.
module cpr_prep import cpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [COORD_W-1:0] src_col,
    input  logic [COORD_W-1:0] src_row,
    input  logic [COLOR_W-1:0] src_color,
    input  logic [DIM_W-1:0]   width,
    input  logic [DIM_W-1:0]   height,
    output logic               valid_reg,
    output cordic_data_t       data_reg
);

    logic signed [OFS_W-1:0]    dx;
    logic signed [OFS_W-1:0]    dy;
    logic signed [OFS_W-1:0]    dx_neg;
    logic signed [OFS_W-1:0]    dy_neg;
    logic signed [CORDIC_W-1:0] u0;
    logic signed [CORDIC_W-1:0] v0;
    cordic_data_t               data_next;

    always_comb
    begin
        dx     = $signed({1'b0, src_col}) - $signed({1'b0, width[DIM_W-1:1]});
        dy     = $signed({1'b0, src_row}) - $signed({1'b0, height[DIM_W-1:1]});
        dx_neg = -dx;
        dy_neg = -dy;
        u0     = CORDIC_W'(dy) <<< GUARD_BITS;
        v0     = CORDIC_W'(dx) <<< GUARD_BITS;

        data_next       = '0;
        data_next.color = src_color;
        data_next.axis  = (dx == '0) || (dy == '0);

        if (dx == '0)
        begin
            data_next.axis_radius = dy[OFS_W-1] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
            data_next.axis_turn   = dy[OFS_W-1] ? TURN_HALF : '0;
        end
        else
        begin
            data_next.axis_radius = dx[OFS_W-1] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
            data_next.axis_turn   = dx[OFS_W-1] ? TURN_3QUARTER : TURN_QUARTER;
        end

        // Vectors in the lower half-plane are turned by a quarter turn first.
        if (u0[CORDIC_W-1])
        begin
            if (!v0[CORDIC_W-1])
            begin
                data_next.u = v0;
                data_next.v = -u0;
                data_next.z = ANGLE_W'(TURN_QUARTER);
            end
            else
            begin
                data_next.u = -v0;
                data_next.v = u0;
                data_next.z = -ANGLE_W'(TURN_QUARTER);
            end
        end
        else
        begin
            data_next.u = u0;
            data_next.v = v0;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/cpr_cordic_stage.sv @@
// One registered CORDIC vectoring micro-rotation.
module cpr_cordic_stage import cpr_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  cordic_data_t in_data,
    output logic         valid_reg,
    output cordic_data_t data_reg
);

    localparam logic [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(atan_turn(STEP));

    logic signed [CORDIC_W-1:0] u_shift;
    logic signed [CORDIC_W-1:0] v_shift;
    cordic_data_t               data_next;

    always_comb
    begin
        u_shift   = in_data.u >>> STEP;
        v_shift   = in_data.v >>> STEP;
        data_next = in_data;
        if (!in_data.v[CORDIC_W-1])
        begin
            data_next.u = in_data.u + v_shift;
            data_next.v = in_data.v - u_shift;
            data_next.z = in_data.z + $signed(STEP_ANGLE);
        end
        else
        begin
            data_next.u = in_data.u - v_shift;
            data_next.v = in_data.v + u_shift;
            data_next.z = in_data.z - $signed(STEP_ANGLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/cpr_scale.sv @@
// Gain correction and row scaling multipliers, then radius clamp and row sum.
module cpr_scale import cpr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  cordic_data_t     in_data,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    output logic             valid_reg,
    output result_t          result
);

    logic [TURN_W-1:0]      turn_sel;
    logic [MAG_PROD_W-1:0]  mag_prod_reg;
    logic [TURN_PROD_W-1:0] turn_prod_reg;
    logic                   axis_reg;
    logic [COORD_W-1:0]     axis_radius_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic [RADIUS_W-1:0]    radius;

    assign turn_sel = in_data.axis ? in_data.axis_turn : in_data.z[TURN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_prod_reg    <= MAG_PROD_W'(in_data.u[MAG_W-1:0]) * MAG_PROD_W'(INV_GAIN_Q20);
            turn_prod_reg   <= TURN_PROD_W'(turn_sel) * TURN_PROD_W'(height);
            axis_reg        <= in_data.axis;
            axis_radius_reg <= in_data.axis_radius;
            color_reg       <= in_data.color;
        end
    end

    always_comb
    begin
        radius = axis_reg ? RADIUS_W'(axis_radius_reg)
                          : mag_prod_reg[MAG_SHIFT+RADIUS_W-1:MAG_SHIFT];
        result.dest_col   = (radius > RADIUS_W'(MAX_DIM - 1)) ? COORD_W'(MAX_DIM - 1)
                                                              : radius[COORD_W-1:0];
        result.dest_row   = ROW_W'(height[DIM_W-1:1])
                          + ROW_W'(turn_prod_reg[TURN_PROD_W-1:TURN_W]);
        result.dest_color = color_reg;
        result.in_range   = radius < RADIUS_W'(width);
    end

endmodule

@@ sv/cpr_skid.sv @@
// Output register with a skid entry so the pipeline stalls on a registered signal.
module cpr_skid import cpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  result_t       in_data,
    output logic          in_ready,
    cpr_dst_if.source     dst
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;
    logic    load_out;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;
    assign load_out = !out_valid_reg || dst.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg || take;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign dst.valid      = out_valid_reg;
    assign dst.dest_col   = out_data_reg.dest_col;
    assign dst.dest_row   = out_data_reg.dest_row;
    assign dst.dest_color = out_data_reg.dest_color;
    assign dst.in_range   = out_data_reg.in_range;

endmodule
